>>> rtl/llwd_pkg.sv
package llwd_pkg;

    // Field widths of the request, response and configuration channels
    localparam int WORKER_W   = 4;
    localparam int STATUS_W   = 2;
    localparam int TOTAL_W    = 20;
    localparam int ACTIVE_W   = 5;
    localparam int LIMIT_W    = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCED  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL = 4'd3;

    // Register values after reset
    localparam logic                  RST_BALANCED  = 1'b1;
    localparam logic [ACTIVE_W-1:0]   RST_ACTIVE    = 5'd16;
    localparam logic [LIMIT_W-1:0]    RST_MAX_PER   = 16'd1024;
    localparam logic [TOTAL_W-1:0]    RST_MAX_TOTAL = 20'd16384;

    // Request operations
    localparam logic OP_ASSIGN = 1'b0;
    localparam logic OP_CLOSE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_NO_ROOM     = 2'd1,
        ST_TOTAL_FULL  = 2'd2,
        ST_CLOSE_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic                balanced;
        logic [ACTIVE_W-1:0] active;
        logic [LIMIT_W-1:0]  max_per;
        logic [TOTAL_W-1:0]  max_total;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_CRD,
        S_CEV,
        S_RESP
    } t_state;

endpackage

>>> rtl/llwd_if.sv
interface llwd_req_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [llwd_pkg::WORKER_W-1:0] close_worker;

    modport source (output valid, output op, output close_worker, input ready);
    modport sink   (input valid, input op, input close_worker, output ready);
endinterface

interface llwd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [llwd_pkg::WORKER_W-1:0] worker;
    logic [llwd_pkg::STATUS_W-1:0] status;
    logic [llwd_pkg::TOTAL_W-1:0]  total_now;

    modport source (output valid, output worker, output status, output total_now,
                    input ready);
    modport sink   (input valid, input worker, input status, input total_now,
                    output ready);
endinterface

interface llwd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [llwd_pkg::CFG_IDX_W-1:0]  index;
    logic [llwd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/llwd_ram.sv
module llwd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/llwd_cfg.sv
module llwd_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    llwd_cfg_if.sink       i_cfg,
    output llwd_pkg::t_cfg o_cfg
);

    llwd_pkg::t_cfg r_cfg;
    llwd_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    // Decode a write request into the addressed register
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                llwd_pkg::CFG_BALANCED:  n_cfg.balanced  = i_cfg.data[0];
                llwd_pkg::CFG_ACTIVE:    n_cfg.active    = i_cfg.data[llwd_pkg::ACTIVE_W-1:0];
                llwd_pkg::CFG_MAX_PER:   n_cfg.max_per   = i_cfg.data[llwd_pkg::LIMIT_W-1:0];
                llwd_pkg::CFG_MAX_TOTAL: n_cfg.max_total = i_cfg.data[llwd_pkg::TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.balanced  <= llwd_pkg::RST_BALANCED;
            r_cfg.active    <= llwd_pkg::RST_ACTIVE;
            r_cfg.max_per   <= llwd_pkg::RST_MAX_PER;
            r_cfg.max_total <= llwd_pkg::RST_MAX_TOTAL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/llwd_ctrl.sv
module llwd_ctrl #(
    parameter int MAX_WORKERS = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  llwd_pkg::t_cfg                         i_cfg,
    llwd_req_if.sink                               i_req,
    llwd_rsp_if.source                             o_rsp,
    output logic                                   o_rd_en,
    output logic [(MAX_WORKERS > 1 ? $clog2(MAX_WORKERS) : 1)-1:0] o_rd_addr,
    input  logic [COUNT_WIDTH-1:0]                 i_rd_data,
    output logic                                   o_wr_en,
    output logic [(MAX_WORKERS > 1 ? $clog2(MAX_WORKERS) : 1)-1:0] o_wr_addr,
    output logic [COUNT_WIDTH-1:0]                 o_wr_data
);

    localparam int WIDX = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CMPW = (COUNT_WIDTH > llwd_pkg::LIMIT_W) ? COUNT_WIDTH : llwd_pkg::LIMIT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_FULL = '1;

    llwd_pkg::t_state              r_state, n_state;
    logic [WIDX-1:0]               r_idx, n_idx;
    logic [WIDX-1:0]               r_last, n_last;
    logic                          r_issued_all, n_issued_all;
    logic                          r_dv, n_dv;
    logic [WIDX-1:0]               r_didx, n_didx;
    logic [WIDX-1:0]               r_best_idx, n_best_idx;
    logic [COUNT_WIDTH-1:0]        r_best_cnt, n_best_cnt;
    logic                          r_found, n_found;
    logic [MAX_WORKERS-1:0]        r_valid, n_valid;
    logic [llwd_pkg::TOTAL_W-1:0]  r_total, n_total;
    logic [llwd_pkg::WORKER_W-1:0] r_res_worker, n_res_worker;
    llwd_pkg::t_status             r_res_status, n_res_status;
    logic                          r_out_valid, n_out_valid;
    logic [llwd_pkg::WORKER_W-1:0] r_out_worker, n_out_worker;
    llwd_pkg::t_status             r_out_status, n_out_status;
    logic [llwd_pkg::TOTAL_W-1:0]  r_out_total, n_out_total;

    logic [31:0]            used_n;
    logic [31:0]            used_m1;
    logic [31:0]            cw_ext;
    logic [31:0]            best_ext;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic                   pick_ok;

    function automatic logic f_room(input logic [COUNT_WIDTH-1:0] c,
                                    input logic [llwd_pkg::LIMIT_W-1:0] lim);
        return (CMPW'(c) < CMPW'(lim)) && (c != CNT_FULL);
    endfunction

    // Clamp the active worker count into the built range
    always_comb begin
        used_n = 32'(i_cfg.active);
        if (used_n == 32'd0) begin
            used_n = 32'd1;
        end
        if (used_n > 32'(MAX_WORKERS)) begin
            used_n = 32'(MAX_WORKERS);
        end
        used_m1 = used_n - 32'd1;
    end

    assign cw_ext   = 32'(i_req.close_worker);
    assign best_ext = 32'(r_best_idx);

    // Entries never written read as zero
    assign cur_cnt = r_valid[r_didx] ? i_rd_data : '0;
    assign pick_ok = i_cfg.balanced ? f_room(r_best_cnt, i_cfg.max_per) : r_found;

    // Sequencer: an assign scans the count memory, a close reads one entry; then one entry may be updated
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_last       = r_last;
        n_issued_all = r_issued_all;
        n_dv         = 1'b0;
        n_didx       = r_didx;
        n_best_idx   = r_best_idx;
        n_best_cnt   = r_best_cnt;
        n_found      = r_found;
        n_valid      = r_valid;
        n_total      = r_total;
        n_res_worker = r_res_worker;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_worker = r_out_worker;
        n_out_status = r_out_status;
        n_out_total  = r_out_total;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_idx;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_didx;
        o_wr_data    = cur_cnt - 1'b1;
        i_req.ready  = (r_state == llwd_pkg::S_IDLE);

        // Drop the output once it is taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            llwd_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.op == llwd_pkg::OP_ASSIGN) begin
                        n_res_worker = '0;
                        if (r_total >= i_cfg.max_total) begin
                            n_res_status = llwd_pkg::ST_TOTAL_FULL;
                            n_state      = llwd_pkg::S_RESP;
                        end else begin
                            n_idx        = '0;
                            n_last       = used_m1[WIDX-1:0];
                            n_issued_all = 1'b0;
                            n_found      = 1'b0;
                            n_state      = llwd_pkg::S_SCAN;
                        end
                    end else begin
                        n_res_worker = i_req.close_worker;
                        if (cw_ext >= 32'(MAX_WORKERS)) begin
                            n_res_status = llwd_pkg::ST_CLOSE_EMPTY;
                            n_state      = llwd_pkg::S_RESP;
                        end else begin
                            n_idx   = cw_ext[WIDX-1:0];
                            n_state = llwd_pkg::S_CRD;
                        end
                    end
                end
            end

            llwd_pkg::S_SCAN: begin
                // Issue one read a cycle until the last active worker
                if (!r_issued_all) begin
                    o_rd_en      = 1'b1;
                    n_dv         = 1'b1;
                    n_didx       = r_idx;
                    n_idx        = r_idx + 1'b1;
                    n_issued_all = (r_idx == r_last);
                end
                // Compare the count that returned from the previous read
                if (r_dv) begin
                    if (i_cfg.balanced) begin
                        if ((r_didx == '0) || (cur_cnt < r_best_cnt)) begin
                            n_best_cnt = cur_cnt;
                            n_best_idx = r_didx;
                        end
                    end else if (!r_found && f_room(cur_cnt, i_cfg.max_per)) begin
                        n_found    = 1'b1;
                        n_best_cnt = cur_cnt;
                        n_best_idx = r_didx;
                    end
                    if (r_didx == r_last) begin
                        n_state = llwd_pkg::S_PICK;
                    end
                end
            end

            llwd_pkg::S_PICK: begin
                if (pick_ok) begin
                    o_wr_en             = 1'b1;
                    o_wr_addr           = r_best_idx;
                    o_wr_data           = r_best_cnt + 1'b1;
                    n_valid[r_best_idx] = 1'b1;
                    n_total             = r_total + 1'b1;
                    n_res_worker        = best_ext[llwd_pkg::WORKER_W-1:0];
                    n_res_status        = llwd_pkg::ST_OK;
                end else begin
                    n_res_worker = '0;
                    n_res_status = llwd_pkg::ST_NO_ROOM;
                end
                n_state = llwd_pkg::S_RESP;
            end

            llwd_pkg::S_CRD: begin
                o_rd_en = 1'b1;
                n_didx  = r_idx;
                n_state = llwd_pkg::S_CEV;
            end

            llwd_pkg::S_CEV: begin
                if (cur_cnt == '0) begin
                    n_res_status = llwd_pkg::ST_CLOSE_EMPTY;
                end else begin
                    o_wr_en         = 1'b1;
                    n_valid[r_didx] = 1'b1;
                    if (r_total != '0) begin
                        n_total = r_total - 1'b1;
                    end
                    n_res_status = llwd_pkg::ST_OK;
                end
                n_state = llwd_pkg::S_RESP;
            end

            llwd_pkg::S_RESP: begin
                // Hold the result until the output register frees up
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_worker = r_res_worker;
                    n_out_status = r_res_status;
                    n_out_total  = r_total;
                    n_state      = llwd_pkg::S_IDLE;
                end
            end

            default: n_state = llwd_pkg::S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= llwd_pkg::S_IDLE;
            r_dv        <= 1'b0;
            r_valid     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dv        <= n_dv;
            r_valid     <= n_valid;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_last       <= n_last;
        r_issued_all <= n_issued_all;
        r_didx       <= n_didx;
        r_best_idx   <= n_best_idx;
        r_best_cnt   <= n_best_cnt;
        r_found      <= n_found;
        r_res_worker <= n_res_worker;
        r_res_status <= n_res_status;
        r_out_worker <= n_out_worker;
        r_out_status <= n_out_status;
        r_out_total  <= n_out_total;
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.worker    = r_out_worker;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.total_now = r_out_total;

endmodule

>>> rtl/least_loaded_worker_dispatch_top.sv
// Channel   Dir  Handshake      Payload
// i_req     in   valid/ready    op, close_worker
// o_rsp     out  valid/ready    worker, status, total_now
// i_cfg     in   valid/ready    index, data (always ready)
//
// An assign request goes from acceptance through the scan, which reads one
// worker count per cycle from the count memory, and the pick state to the
// response register. A close reads, updates and responds; a refusal on the total
// limit or on an unbuilt worker goes straight to the respond state. The sequencer
// is back in idle, ready for the next request, once the response is registered.
// Reset is synchronous; counts clear at once through per-entry valid bits.
// A new request is taken while a response still waits in the output register;
// a full output register holds the sequencer in its respond state.
module least_loaded_worker_dispatch_top #(
    parameter int MAX_WORKERS = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    llwd_req_if.sink   i_req,
    llwd_rsp_if.source o_rsp,
    llwd_cfg_if.sink   i_cfg
);

    localparam int WIDX = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

    llwd_pkg::t_cfg         cfg;
    logic                   rd_en;
    logic [WIDX-1:0]        rd_addr;
    logic [COUNT_WIDTH-1:0] rd_data;
    logic                   wr_en;
    logic [WIDX-1:0]        wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    llwd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    llwd_ctrl #(
        .MAX_WORKERS (MAX_WORKERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    llwd_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_WORKERS)
    ) u_count_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

endmodule

>>> rtl/llwd_chk.sv
module llwd_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [llwd_pkg::WORKER_W-1:0] i_rsp_worker,
    input logic [llwd_pkg::STATUS_W-1:0] i_rsp_status,
    input logic [llwd_pkg::TOTAL_W-1:0]  i_rsp_total
);

    logic                         req_acc;
    logic                         rsp_acc;
    logic [2:0]                   r_pend;
    logic                         r_have_prev;
    logic [llwd_pkg::TOTAL_W-1:0] r_prev_total;

    assign req_acc = i_req_valid && i_req_ready;
    assign rsp_acc = i_rsp_valid && i_rsp_ready;

    // Track requests in flight and the last total shown
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_have_prev <= 1'b0;
        end else begin
            r_pend <= r_pend + {2'b00, req_acc} - {2'b00, rsp_acc};
            if (rsp_acc) begin
                r_have_prev <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_acc) begin
            r_prev_total <= i_rsp_total;
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_worker)
            && $stable(i_rsp_status) && $stable(i_rsp_total))
        else $error("response changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_acc |-> r_pend != 3'd0)
        else $error("response without a pending request");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd2)
        else $error("more than two requests in flight");

    a_refuse_worker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_acc && (i_rsp_status == llwd_pkg::ST_NO_ROOM
            || i_rsp_status == llwd_pkg::ST_TOTAL_FULL) |-> i_rsp_worker == '0)
        else $error("refused assign names a worker");

    a_refuse_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_acc && r_have_prev && i_rsp_status != llwd_pkg::ST_OK
            |-> i_rsp_total == r_prev_total)
        else $error("refused request changed the total");

endmodule

bind least_loaded_worker_dispatch_top llwd_chk u_llwd_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_worker (o_rsp.worker),
    .i_rsp_status (o_rsp.status),
    .i_rsp_total  (o_rsp.total_now)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import llwd_pkg::*;

    localparam int NUM_WORKERS  = 16;
    localparam int COUNT_W      = 16;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 900;
    localparam int MAX_REPORTS  = 10;

    // Register index that decodes to nothing; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;

    typedef struct packed {
        logic [WORKER_W-1:0] worker;
        t_status             status;
        logic [TOTAL_W-1:0]  total_now;
    } t_reply;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    llwd_req_if req_if ();
    llwd_rsp_if rsp_if ();
    llwd_cfg_if cfg_if ();

    least_loaded_worker_dispatch_top #(
        .MAX_WORKERS(NUM_WORKERS),
        .COUNT_WIDTH(COUNT_W)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if),
        .i_cfg  (cfg_if)
    );

    // Shadow copy of the connection counts and registers
    logic [COUNT_W-1:0] worker_load [NUM_WORKERS];
    logic [TOTAL_W-1:0] conn_total;
    t_cfg               shadow_cfg;

    t_reply owed_replies[$];
    int     requests_sent  = 0;
    int     replies_seen   = 0;
    int     mismatch_count = 0;
    int     quiet_cycles   = 0;
    int     stall_left     = 0;
    bit     idle_en        = 1'b1;
    bit     stall_en       = 1'b1;

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit has_room(input logic [COUNT_W-1:0] c);
        // a saturated counter is full no matter what the limit says
        return (c < shadow_cfg.max_per) && (c != '1);
    endfunction

    // Pick a worker or retire a connection, and update the shadow counts
    function automatic t_reply dispatch_step(input logic op, input logic [WORKER_W-1:0] cw);
        t_reply r;
        int     n;
        int     best;
        bit     found;
        r.worker = '0;
        r.status = ST_OK;
        best     = 0;
        found    = 1'b0;
        if (op == OP_ASSIGN) begin
            if (conn_total >= shadow_cfg.max_total) begin
                r.status = ST_TOTAL_FULL;
            end else begin
                // clamp the worker count into 1..NUM_WORKERS
                if (shadow_cfg.active == 0)
                    n = 1;
                else if (shadow_cfg.active > NUM_WORKERS)
                    n = NUM_WORKERS;
                else
                    n = int'(shadow_cfg.active);
                if (shadow_cfg.balanced) begin
                    for (int i = 1; i < n; i++)
                        if (worker_load[i] < worker_load[best])
                            best = i;
                    found = has_room(worker_load[best]);
                end else begin
                    for (int i = n - 1; i >= 0; i--)
                        if (has_room(worker_load[i])) begin
                            best  = i;
                            found = 1'b1;
                        end
                end
                if (found) begin
                    worker_load[best] = worker_load[best] + 1'b1;
                    conn_total        = conn_total + 1'b1;
                    r.worker          = WORKER_W'(best);
                end else begin
                    r.status = ST_NO_ROOM;
                end
            end
        end else begin
            r.worker = cw;
            if (int'(cw) >= NUM_WORKERS || worker_load[cw] == 0) begin
                r.status = ST_CLOSE_EMPTY;
            end else begin
                worker_load[cw] = worker_load[cw] - 1'b1;
                if (conn_total != 0)
                    conn_total = conn_total - 1'b1;
            end
        end
        r.total_now = conn_total;
        return r;
    endfunction

    function automatic void report_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, msg);
    endfunction

    // Track register writes, check replies, predict each accepted request
    always @(posedge clk) begin : monitor
        t_reply got;
        t_reply want;
        if (!rst_n) begin
            foreach (worker_load[i])
                worker_load[i] = '0;
            conn_total = '0;
            shadow_cfg = '{RST_BALANCED, RST_ACTIVE, RST_MAX_PER, RST_MAX_TOTAL};
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    CFG_BALANCED:  shadow_cfg.balanced  = cfg_if.data[0];
                    CFG_ACTIVE:    shadow_cfg.active    = cfg_if.data[ACTIVE_W-1:0];
                    CFG_MAX_PER:   shadow_cfg.max_per   = cfg_if.data[LIMIT_W-1:0];
                    CFG_MAX_TOTAL: shadow_cfg.max_total = cfg_if.data[TOTAL_W-1:0];
                    default: ;
                endcase
            end
            if (rsp_if.valid && rsp_if.ready) begin
                replies_seen++;
                got.worker    = rsp_if.worker;
                got.status    = t_status'(rsp_if.status);
                got.total_now = rsp_if.total_now;
                if (owed_replies.size() == 0) begin
                    report_error($sformatf("reply with nothing owed: worker %0d status %0d total %0d",
                                           got.worker, got.status, got.total_now));
                end else begin
                    want = owed_replies.pop_front();
                    if (got.worker !== want.worker || got.status !== want.status ||
                        got.total_now !== want.total_now)
                        report_error($sformatf(
                            "expected worker %0d status %0d total %0d, got worker %0d status %0d total %0d",
                            want.worker, want.status, want.total_now,
                            got.worker, got.status, got.total_now));
                end
            end
            if (req_if.valid && req_if.ready)
                owed_replies.push_back(dispatch_step(req_if.op, req_if.close_worker));
        end
    end

    // Stall the reply channel at random
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
        end else begin
            rsp_if.ready <= 1'b1;
            if (stall_en)
                stall_left = pick_gap();
        end
    end

    // Abort when no channel moves for too long
    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    // Present one request, leave valid high after it is taken
    task automatic send_request(input logic op, input logic [WORKER_W-1:0] cw);
        int gap;
        gap = idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.op           <= op;
        req_if.close_worker <= cw;
        do @(posedge clk); while (!req_if.ready);
        requests_sent++;
    endtask

    // Hold the sender until every owed reply is back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (replies_seen < requests_sent)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit last);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        if (last)
            cfg_if.valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        // close on empty workers at both ends, then balanced assigns and a refill
        send_request(OP_CLOSE, 4'd0);
        send_request(OP_CLOSE, 4'd15);
        repeat (3) send_request(OP_ASSIGN, WORKER_W'($urandom));
        send_request(OP_CLOSE, 4'd1);
        send_request(OP_ASSIGN, WORKER_W'($urandom));
        wait_drained();
    endtask

    task automatic test_limits_and_modes();
        // total already at its limit
        write_reg(CFG_MAX_TOTAL, 20'd3, 1'b1);
        send_request(OP_ASSIGN, WORKER_W'($urandom));
        wait_drained();

        // per-worker limit of zero leaves no room anywhere
        write_reg(CFG_MAX_TOTAL, 20'hFFFFF, 1'b0);
        write_reg(CFG_MAX_PER, 20'd0, 1'b1);
        send_request(OP_ASSIGN, WORKER_W'($urandom));
        wait_drained();

        // first fit with zero active workers, treated as one
        write_reg(CFG_MAX_PER, 20'd1, 1'b0);
        write_reg(CFG_BALANCED, 20'd0, 1'b0);
        write_reg(CFG_ACTIVE, 20'd0, 1'b1);
        send_request(OP_ASSIGN, WORKER_W'($urandom));
        send_request(OP_CLOSE, 4'd0);
        send_request(OP_ASSIGN, WORKER_W'($urandom));
        send_request(OP_ASSIGN, WORKER_W'($urandom));
        wait_drained();

        // oversized worker count, widest per-worker limit
        write_reg(CFG_ACTIVE, 20'd31, 1'b0);
        write_reg(CFG_MAX_PER, 20'hFFFF, 1'b1);
        send_request(OP_ASSIGN, WORKER_W'($urandom));
        wait_drained();
        write_reg(CFG_BALANCED, 20'd1, 1'b1);
        send_request(OP_ASSIGN, WORKER_W'($urandom));
        wait_drained();

        // close above the active range still counts; unused index changes nothing
        write_reg(CFG_ACTIVE, 20'd2, 1'b0);
        write_reg(CFG_UNUSED, 20'hFFFFF, 1'b1);
        send_request(OP_CLOSE, 4'd2);
        send_request(OP_CLOSE, 4'd12);
        send_request(OP_ASSIGN, WORKER_W'($urandom));
        wait_drained();
    endtask

    task automatic test_drain_pause();
        // back-to-back burst, full drain, then another burst
        idle_en = 1'b0;
        repeat (12) send_request(1'($urandom), WORKER_W'($urandom));
        wait_drained();
        repeat (12) send_request(1'($urandom), WORKER_W'($urandom));
        idle_en = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int                  done_items;
        int                  phase_len;
        int                  assign_pct;
        int                  busy[$];
        logic [WORKER_W-1:0] target;
        logic [ACTIVE_W-1:0] act;
        logic [LIMIT_W-1:0]  per;
        logic [TOTAL_W-1:0]  tot;
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            wait_drained();

            // new register settings, extremes weighted in
            case ($urandom_range(0, 5))
                0:       act = 5'd0;
                1:       act = 5'd1;
                2:       act = 5'd16;
                3:       act = ACTIVE_W'($urandom_range(17, 31));
                default: act = ACTIVE_W'($urandom_range(2, 15));
            endcase
            case ($urandom_range(0, 6))
                0:       per = 16'd0;
                1:       per = 16'hFFFF;
                2:       per = LIMIT_W'($urandom_range(1, 3));
                3:       per = LIMIT_W'($urandom);
                default: per = LIMIT_W'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 5))
                0:       tot = 20'd0;
                1:       tot = 20'hFFFFF;
                2:       tot = TOTAL_W'($urandom_range(1, 60));
                3:       tot = TOTAL_W'($urandom);
                default: tot = TOTAL_W'($urandom_range(60, 400));
            endcase
            write_reg(CFG_BALANCED, CFG_DATA_W'($urandom), 1'b0);
            write_reg(CFG_ACTIVE, CFG_DATA_W'({$urandom, act}), 1'b0);
            write_reg(CFG_MAX_PER, CFG_DATA_W'({$urandom, per}), 1'b0);
            write_reg(CFG_MAX_TOTAL, tot, 1'b1);

            idle_en    = ($urandom_range(0, 3) != 0);
            stall_en   = ($urandom_range(0, 3) != 0);
            phase_len  = $urandom_range(50, 100);
            assign_pct = $urandom_range(30, 75);

            repeat (phase_len) begin
                if ($urandom_range(0, 99) < assign_pct) begin
                    send_request(OP_ASSIGN, WORKER_W'($urandom));
                end else begin
                    // mostly close a worker that holds connections
                    busy.delete();
                    foreach (worker_load[i])
                        if (worker_load[i] != 0)
                            busy.push_back(i);
                    if (busy.size() == 0 || $urandom_range(0, 4) == 0)
                        target = WORKER_W'($urandom);
                    else
                        target = WORKER_W'(busy[$urandom_range(0, busy.size() - 1)]);
                    send_request(OP_CLOSE, target);
                end
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
                done_items++;
            end
        end
        idle_en  = 1'b1;
        stall_en = 1'b1;
    endtask

    initial begin
        req_if.valid        <= 1'b0;
        req_if.op           <= OP_ASSIGN;
        req_if.close_worker <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= CFG_BALANCED;
        cfg_if.data         <= '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_limits_and_modes();
        test_drain_pause();
        test_random_traffic();

        // let any stray reply show up before the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (owed_replies.size() != 0)
            report_error($sformatf("%0d replies never arrived", owed_replies.size()));

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
